>>> src/wrpm_pkg.sv
// Shared constants, configuration types and register indexes of the RMS and peak meter.
package wrpm_pkg;

  localparam int MAX_CHANNELS_DEF     = 8;
  localparam int FRAME_COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH          = 2;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int START_W  = 32;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CHCNT_W  = 4;
  // one square is at most 2^30, so a sum of fewer than 2^FCB squares fits in SQ_W + FCB bits
  localparam int SQ_W     = 30;
  // mean square never exceeds 2^30
  localparam int QUO_W    = 32;

  localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = CHCNT_W'(1);
  localparam logic [CFG_W-1:0]   WINDOW_FRAMES_RST = CFG_W'(1024);
  localparam logic [CFG_W-1:0]   QUIET_THR_RST     = CFG_W'(328);
  localparam logic [CFG_W-1:0]   LOUD_THR_RST      = CFG_W'(16384);

  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_WINDOW_FRAMES = 2'd1,
    CFG_QUIET_THR     = 2'd2,
    CFG_LOUD_THR      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CHCNT_W-1:0] channel_count;
    logic [CFG_W-1:0]   window_frames;
    logic [CFG_W-1:0]   quiet_threshold;
    logic [CFG_W-1:0]   loud_threshold;
  } cfg_t;

endpackage

>>> src/wrpm_in_if.sv
// Sample input channel: valid/ready handshake with one PCM sample per transaction.
interface wrpm_in_if;
  import wrpm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_of_buffer;

  modport source (output valid, sample, last_of_buffer, input ready);
  modport sink   (input valid, sample, last_of_buffer, output ready);
endinterface

>>> src/wrpm_out_if.sv
// Result output channel: valid/ready handshake with one window measurement per transaction.
interface wrpm_out_if;
  import wrpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [START_W-1:0] start_frame;
  logic [COUNT_W-1:0] frame_count;
  logic [LEVEL_W-1:0] rms_level;
  logic [LEVEL_W-1:0] peak_level;
  logic               is_quiet;
  logic               is_loud;

  modport source (output valid, start_frame, frame_count, rms_level, peak_level, is_quiet,
                  is_loud, input ready);
  modport sink   (input valid, start_frame, frame_count, rms_level, peak_level, is_quiet,
                  is_loud, output ready);
endinterface

>>> src/wrpm_fifo.sv
// Small register queue carrying closed-window jobs from the front end to the back end.
module wrpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             nonempty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

>>> src/wrpm_front.sv
// Front end: frame tracking, square/peak accumulation and window close detection.
module wrpm_front #(
  parameter int MAX_CHANNELS     = 8,
  parameter int FRAME_COUNT_BITS = 16,
  parameter int JOB_W            = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [wrpm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_last,
  output logic                          in_ready,
  input  wrpm_pkg::cfg_t                cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [JOB_W-1:0]              q_data
);
  import wrpm_pkg::*;

  localparam int FCB   = FRAME_COUNT_BITS;
  localparam int SUM_W = SQ_W + FCB;
  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_W  = ($clog2(MAX_CHANNELS + 1) > CHCNT_W) ? $clog2(MAX_CHANNELS + 1)
                                                               : CHCNT_W;
  localparam int WC_W  = (FCB > CFG_W) ? FCB : CFG_W;
  localparam logic [CH_W-1:0] MAX_CH = CH_W'(MAX_CHANNELS);
  localparam logic [WC_W-1:0] WMAX   = WC_W'((64'd1 << FCB) - 64'd1);

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [FCB-1:0]     count;
    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] peak;
  } job_t;

  logic [SUM_W-1:0]           sum_r, sum_nxt, sum_acc;
  logic [LEVEL_W-1:0]         peak_r, peak_nxt, peak_acc;
  logic [FCB-1:0]             fs_r, fs_nxt, fs_acc;
  logic [POS_W-1:0]           pos_r, pos_nxt, pos_eff;
  logic [START_W-1:0]         ws_r, ws_nxt;
  logic signed [SAMPLE_W-1:0] pend_r, pend_nxt, pend;

  logic [CH_W-1:0]      chans;
  logic [WC_W-1:0]      win_ext;
  logic [FCB-1:0]       win;
  logic                 frame_done, close, accept;
  logic [LEVEL_W-1:0]   mag;
  logic [2*LEVEL_W-1:0] sq;
  job_t                 job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    chans = CH_W'(cfg.channel_count);
    if (chans == '0) begin
      chans = CH_W'(1);
    end else if (chans > MAX_CH) begin
      chans = MAX_CH;
    end

    win_ext = WC_W'(cfg.window_frames);
    if (win_ext == '0) begin
      win_ext = WC_W'(1);
    end else if (win_ext > WMAX) begin
      win_ext = WMAX;
    end
    win = win_ext[FCB-1:0];

    pos_eff    = (CH_W'(pos_r) >= chans) ? '0 : pos_r;
    pend       = (pos_eff == '0) ? in_sample : pend_r;
    frame_done = (CH_W'(pos_eff) == chans - 1'b1);

    // two's complement negate also covers -32768 -> 32768 in 16 unsigned bits
    mag = pend[SAMPLE_W-1] ? LEVEL_W'(~pend + 1'b1) : LEVEL_W'(pend);
    sq  = mag * mag;

    sum_acc  = frame_done ? sum_r + SUM_W'(sq) : sum_r;
    peak_acc = (frame_done && (mag > peak_r)) ? mag : peak_r;
    fs_acc   = frame_done ? fs_r + 1'b1 : fs_r;
    pos_nxt  = frame_done ? '0 : pos_eff + 1'b1;

    close = (fs_acc != '0) && (in_last || (frame_done && (fs_acc >= win)));

    pend_nxt = pend;
    if (in_last) begin
      ws_nxt   = '0;
      pos_nxt  = '0;
      sum_nxt  = '0;
      peak_nxt = '0;
      fs_nxt   = '0;
      pend_nxt = '0;
    end else if (close) begin
      ws_nxt   = ws_r + START_W'(fs_acc);
      sum_nxt  = '0;
      peak_nxt = '0;
      fs_nxt   = '0;
    end else begin
      ws_nxt   = ws_r;
      sum_nxt  = sum_acc;
      peak_nxt = peak_acc;
      fs_nxt   = fs_acc;
    end

    job.start = ws_r;
    job.count = fs_acc;
    job.sum   = sum_acc;
    job.peak  = peak_acc;
  end

  assign q_push = accept && close;
  assign q_data = JOB_W'(job);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      peak_r <= '0;
      fs_r   <= '0;
      pos_r  <= '0;
      ws_r   <= '0;
      pend_r <= '0;
    end else if (accept) begin
      sum_r  <= sum_nxt;
      peak_r <= peak_nxt;
      fs_r   <= fs_nxt;
      pos_r  <= pos_nxt;
      ws_r   <= ws_nxt;
      pend_r <= pend_nxt;
    end
  end
endmodule

>>> src/wrpm_back.sv
// Back end: iterative mean-square divide, iterative square root and result register.
module wrpm_back #(
  parameter int FRAME_COUNT_BITS = 16,
  parameter int JOB_W            = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [JOB_W-1:0]               q_data,
  input  logic                           q_nonempty,
  output logic                           q_pop,
  input  wrpm_pkg::cfg_t                 cfg,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wrpm_pkg::START_W-1:0]   out_start_frame,
  output logic [wrpm_pkg::COUNT_W-1:0]   out_frame_count,
  output logic [wrpm_pkg::LEVEL_W-1:0]   out_rms_level,
  output logic [wrpm_pkg::LEVEL_W-1:0]   out_peak_level,
  output logic                           out_is_quiet,
  output logic                           out_is_loud
);
  import wrpm_pkg::*;

  localparam int FCB   = FRAME_COUNT_BITS;
  localparam int SUM_W = SQ_W + FCB;
  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);
  localparam logic [QUO_W-1:0] BIT_INIT = QUO_W'(1) << (QUO_W - 2);

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [FCB-1:0]     count;
    logic [SUM_W-1:0]   sum;
    logic [LEVEL_W-1:0] peak;
  } job_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_OUT} state_t;

  state_t             state_r;
  job_t               job;
  logic [START_W-1:0] start_r;
  logic [FCB-1:0]     count_r;
  logic [LEVEL_W-1:0] peak_r;
  logic [FCB-1:0]     rem_r;
  logic [SUM_W-1:0]   quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [QUO_W-1:0]   val_r, root_r, bit_r;

  logic               out_valid_r, quiet_r, loud_r;
  logic [START_W-1:0] o_start_r;
  logic [COUNT_W-1:0] o_count_r;
  logic [LEVEL_W-1:0] o_rms_r, o_peak_r;

  logic [FCB:0]       trial, diff;
  logic               ge, sge;
  logic [FCB-1:0]     rem_step;
  logic [SUM_W-1:0]   quo_step;
  logic [QUO_W-1:0]   tst;
  logic [LEVEL_W-1:0] rms;
  logic               out_free;

  assign job = job_t'(q_data);

  always_comb begin
    // restoring divide, one quotient bit per cycle
    trial    = {rem_r, quo_r[SUM_W-1]};
    diff     = trial - {1'b0, count_r};
    ge       = (trial >= {1'b0, count_r});
    rem_step = ge ? diff[FCB-1:0] : trial[FCB-1:0];
    quo_step = {quo_r[SUM_W-2:0], ge};

    tst = root_r + bit_r;
    sge = (val_r >= tst);
    rms = root_r[LEVEL_W-1:0];

    out_free = !out_valid_r || out_ready;
  end

  assign q_pop = (state_r == ST_IDLE) && q_nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself when it is free
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_nonempty) begin
            start_r <= job.start;
            count_r <= job.count;
            peak_r  <= job.peak;
            quo_r   <= job.sum;
            rem_r   <= '0;
            cnt_r   <= DIV_LAST;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_step;
          quo_r <= quo_step;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            val_r   <= quo_step[QUO_W-1:0];
            root_r  <= '0;
            bit_r   <= BIT_INIT;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sge) begin
            val_r  <= val_r - tst;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_start_r   <= start_r;
            o_count_r   <= COUNT_W'(count_r);
            o_rms_r     <= rms;
            o_peak_r    <= peak_r;
            quiet_r     <= (rms < cfg.quiet_threshold);
            loud_r      <= (rms > cfg.loud_threshold);
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_start_frame = o_start_r;
  assign out_frame_count = o_count_r;
  assign out_rms_level   = o_rms_r;
  assign out_peak_level  = o_peak_r;
  assign out_is_quiet    = quiet_r;
  assign out_is_loud     = loud_r;
endmodule

>>> src/windowed_rms_peak_meter.sv
// Windowed RMS and peak level meter: top level with configuration registers.
//
// in_ch takes interleaved signed 16-bit samples, one transaction per cycle while ready
// is high; only the channel-zero sample of each frame is measured. last_of_buffer closes
// a partial window and restarts frame numbering at zero. out_ch delivers one transaction
// per closed window with start frame, frame count, RMS, peak and quiet/loud flags.
// Samples are taken at one per cycle while the queue is not full. A window close hands
// a job to a two-entry queue; the back end runs the divide (one quotient bit per cycle)
// and then the square root (one root bit per cycle), and takes the next job only after
// the previous result has been loaded into the output register.
// in_ch.ready drops only while both queue entries hold closed windows.
// A stalled out_ch holds the finished result in its output register; the back end then
// waits with the next result ready and the front keeps accepting until the queue fills.
// Reset (rst_n low, synchronous) loads the default configuration and clears all
// accumulators and the queue. cfg_we writes register cfg_index with cfg_wdata.
module windowed_rms_peak_meter #(
  parameter int MAX_CHANNELS     = wrpm_pkg::MAX_CHANNELS_DEF,
  parameter int FRAME_COUNT_BITS = wrpm_pkg::FRAME_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wrpm_in_if.sink                     in_ch,
  wrpm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  wrpm_pkg::cfg_idx_t          cfg_index,
  input  logic [wrpm_pkg::CFG_W-1:0]  cfg_wdata
);
  import wrpm_pkg::*;

  localparam int SUM_W = SQ_W + FRAME_COUNT_BITS;
  localparam int JOB_W = START_W + FRAME_COUNT_BITS + SUM_W + LEVEL_W;

  cfg_t             cfg_r;
  logic             q_push, q_pop, q_full, q_nonempty;
  logic [JOB_W-1:0] q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count   <= CHANNEL_COUNT_RST;
      cfg_r.window_frames   <= WINDOW_FRAMES_RST;
      cfg_r.quiet_threshold <= QUIET_THR_RST;
      cfg_r.loud_threshold  <= LOUD_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: cfg_r.channel_count   <= cfg_wdata[CHCNT_W-1:0];
        CFG_WINDOW_FRAMES: cfg_r.window_frames   <= cfg_wdata;
        CFG_QUIET_THR:     cfg_r.quiet_threshold <= cfg_wdata;
        CFG_LOUD_THR:      cfg_r.loud_threshold  <= cfg_wdata;
      endcase
    end
  end

  wrpm_front #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
    .JOB_W           (JOB_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_sample(in_ch.sample),
    .in_last  (in_ch.last_of_buffer),
    .in_ready (in_ch.ready),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  wrpm_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .nonempty(q_nonempty)
  );

  wrpm_back #(
    .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
    .JOB_W           (JOB_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_rd_data),
    .q_nonempty     (q_nonempty),
    .q_pop          (q_pop),
    .cfg            (cfg_r),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_start_frame(out_ch.start_frame),
    .out_frame_count(out_ch.frame_count),
    .out_rms_level  (out_ch.rms_level),
    .out_peak_level (out_ch.peak_level),
    .out_is_quiet   (out_ch.is_quiet),
    .out_is_loud    (out_ch.is_loud)
  );
endmodule

>>> dv/meter_check_pkg.sv
// Window measurement type and the scoreboard that predicts and checks the level meter.
`timescale 1ns / 100ps
package meter_check_pkg;
  import wrpm_pkg::*;

  typedef struct {
    logic [START_W-1:0] start_frame;
    logic [COUNT_W-1:0] frame_count;
    logic [LEVEL_W-1:0] rms_level;
    logic [LEVEL_W-1:0] peak_level;
    logic               is_quiet;
    logic               is_loud;
  } window_meas_t;

  class meter_scoreboard;
    // register copy
    logic [CHCNT_W-1:0] channel_count;
    logic [CFG_W-1:0]   window_frames;
    logic [CFG_W-1:0]   quiet_thr;
    logic [CFG_W-1:0]   loud_thr;
    // accumulator copy
    logic [45:0]               square_sum;
    logic [LEVEL_W-1:0]        peak_mag;
    logic [COUNT_W-1:0]        frames_seen;
    logic [2:0]                chan_pos;
    logic [START_W-1:0]        window_start;
    logic signed [SAMPLE_W-1:0] held_sample;

    window_meas_t expected_windows[$];
    int error_count;
    int windows_checked;

    function new();
      channel_count   = CHANNEL_COUNT_RST;
      window_frames   = WINDOW_FRAMES_RST;
      quiet_thr       = QUIET_THR_RST;
      loud_thr        = LOUD_THR_RST;
      square_sum      = '0;
      peak_mag        = '0;
      frames_seen     = '0;
      chan_pos        = '0;
      window_start    = '0;
      held_sample     = '0;
      error_count     = 0;
      windows_checked = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_CHANNEL_COUNT: channel_count = value[CHCNT_W-1:0];
        CFG_WINDOW_FRAMES: window_frames = value;
        CFG_QUIET_THR:     quiet_thr = value;
        CFG_LOUD_THR:      loud_thr = value;
        default: ;
      endcase
    endfunction

    // floor square root, one result bit at a time
    function logic [LEVEL_W-1:0] root_floor(logic [45:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 23; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= {18'd0, v}) root = trial;
      end
      return root[LEVEL_W-1:0];
    endfunction

    function void absorb_sample(logic signed [SAMPLE_W-1:0] s, logic is_last);
      int unsigned  chans;
      int unsigned  win;
      logic         frame_done;
      logic         window_close;
      logic [15:0]  mag;
      logic [45:0]  mean_square;
      logic [LEVEL_W-1:0] rms;
      window_meas_t meas;

      chans = channel_count;
      if (chans == 0) chans = 1;
      if (chans > MAX_CHANNELS_DEF) chans = MAX_CHANNELS_DEF;
      win = window_frames;
      if (win == 0) win = 1;
      if (chan_pos >= chans) chan_pos = '0;

      if (chan_pos == 0) held_sample = s;
      frame_done = (chan_pos == chans - 1);
      if (frame_done) begin
        mag = held_sample[SAMPLE_W-1] ? (~held_sample + 16'd1) : held_sample;
        square_sum = square_sum + 46'(mag) * 46'(mag);
        if (mag > peak_mag) peak_mag = mag;
        frames_seen = frames_seen + 1'b1;
        chan_pos = '0;
      end else begin
        chan_pos = chan_pos + 1'b1;
      end

      window_close = (frames_seen != 0) && (is_last || (frame_done && frames_seen >= win));
      if (window_close) begin
        mean_square = square_sum / 46'(frames_seen);
        rms = root_floor(mean_square);
        meas.start_frame = window_start;
        meas.frame_count = frames_seen;
        meas.rms_level   = rms;
        meas.peak_level  = peak_mag;
        meas.is_quiet    = rms < quiet_thr;
        meas.is_loud     = rms > loud_thr;
        expected_windows.push_back(meas);
        window_start = window_start + START_W'(frames_seen);
        square_sum  = '0;
        peak_mag    = '0;
        frames_seen = '0;
      end

      // buffer end restarts numbering and drops any partial frame
      if (is_last) begin
        window_start = '0;
        chan_pos     = '0;
        square_sum   = '0;
        peak_mag     = '0;
        frames_seen  = '0;
        held_sample  = '0;
      end
    endfunction

    function void check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
        error_count++;
      end
    endfunction

    function void check_window(window_meas_t got);
      window_meas_t want;
      if (expected_windows.size() == 0) begin
        $error("window result (start_frame %0d) with none expected", got.start_frame);
        error_count++;
        return;
      end
      want = expected_windows.pop_front();
      check_field("start_frame", want.start_frame, got.start_frame);
      check_field("frame_count", 32'(want.frame_count), 32'(got.frame_count));
      check_field("rms_level", 32'(want.rms_level), 32'(got.rms_level));
      check_field("peak_level", 32'(want.peak_level), 32'(got.peak_level));
      check_field("is_quiet", 32'(want.is_quiet), 32'(got.is_quiet));
      check_field("is_loud", 32'(want.is_loud), 32'(got.is_loud));
      windows_checked++;
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction
  endclass

endpackage

>>> dv/testbench.sv
// Top-level testbench of the windowed RMS and peak meter: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module testbench;
  import wrpm_pkg::*;
  import meter_check_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int DIRECTED_SAMPLES = 26;
  localparam int RANDOM_SAMPLES   = 1360;
  localparam int SETTLE_CYCLES    = 90;
  localparam int HOLD_OFF_CYCLES  = 400;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  wrpm_in_if  in_ch ();
  wrpm_out_if out_ch ();

  windowed_rms_peak_meter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  meter_scoreboard meter_sb;
  int unsigned     cycle_count = 0;
  bit              src_idle_on = 1'b1;
  bit              sink_idle_on = 1'b1;
  bit              hold_request = 1'b0;
  int              samples_sent = 0;
  int              settings_used = 0;
  int unsigned     active_chans = 1;
  int unsigned     active_window = 1024;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side: checks each transaction, then picks next ready
  initial begin : result_sink
    int unsigned  hold_left;
    window_meas_t got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.start_frame = out_ch.start_frame;
        got.frame_count = out_ch.frame_count;
        got.rms_level   = out_ch.rms_level;
        got.peak_level  = out_ch.peak_level;
        got.is_quiet    = out_ch.is_quiet;
        got.is_loud     = out_ch.is_loud;
        meter_sb.check_window(got);
      end
      if (hold_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(sink_idle_on && $urandom_range(99) < 34);
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
    while (src_idle_on && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample         <= s;
    in_ch.last_of_buffer <= is_last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    meter_sb.absorb_sample(s, is_last);
    samples_sent++;
  endtask

  // leaves cfg_we high; write_settings lowers it after the last register
  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    meter_sb.write_register(idx, value);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] chans, input logic [CFG_W-1:0] win,
                                input logic [CFG_W-1:0] quiet, input logic [CFG_W-1:0] loud);
    write_register(CFG_CHANNEL_COUNT, chans);
    write_register(CFG_WINDOW_FRAMES, win);
    write_register(CFG_QUIET_THR, quiet);
    write_register(CFG_LOUD_THR, loud);
    cfg_we <= 1'b0;
    active_chans = (chans[CHCNT_W-1:0] == 0) ? 1 :
                   (chans[CHCNT_W-1:0] > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF :
                   chans[CHCNT_W-1:0];
    active_window = (win == 0) ? 1 : win;
    settings_used++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk);
    // back end may still be finishing a window that ends in no transaction
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int unsigned amp);
    int v;
    case ($urandom_range(9))
      0:       v = $urandom_range(1) ? -32768 : 32767;
      1:       v = 0;
      2, 3:    v = $urandom_range(65535) - 32768;
      default: begin
        v = $urandom_range(amp);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return SAMPLE_W'(v);
  endfunction

  // whole frames, optionally cut short inside the last frame
  task automatic send_buffer(input int unsigned frames, input bit cut_frame, input bit ends);
    int unsigned total;
    int unsigned amp;
    case ($urandom_range(3))
      0:       amp = 300;
      1:       amp = 2500;
      2:       amp = 16384;
      default: amp = 32768;
    endcase
    total = frames * active_chans;
    if (cut_frame && active_chans > 1) total = total - $urandom_range(1, active_chans - 1);
    for (int unsigned i = 0; i < total; i++) begin
      send_sample(pick_sample(amp), ends && (i == total - 1));
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          phase_target;
    int unsigned buf_frames;
    logic [CFG_W-1:0] new_chans, new_win, new_quiet, new_loud;

    meter_sb = new();
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_CHANNEL_COUNT;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.sample         <= '0;
    in_ch.last_of_buffer <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: full-scale extremes, window left open
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd1, 1'b0);
    drain_results();

    // two channels, window cut to 2 frames while 3 are already in
    write_settings(2, 2, 0, 32768);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd5, 1'b0);
    // buffer ends mid-frame: one-frame window, then a buffer end that closes no window
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd200, 1'b1);
    send_sample(16'sd9, 1'b1);
    drain_results();

    // zero channel count and zero window length both act as 1
    write_settings(0, 0, 32768, 0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    drain_results();

    // channel count above the maximum clamps to eight
    write_settings(12, 5, 328, 16384);
    send_sample(16'sd20000, 1'b0);
    repeat (7) send_sample(SAMPLE_W'($urandom), 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(-16'sd8, 1'b1);

    phase = 0;
    while (samples_sent < DIRECTED_SAMPLES + RANDOM_SAMPLES) begin
      phase++;
      drain_results();
      src_idle_on  = !(phase inside {[4:6]});
      sink_idle_on = !(phase inside {[4:6]});
      if (phase == 2) begin
        // one window per sample while the result side holds off
        write_settings(1, 1, $urandom_range(32768), $urandom_range(32768));
        hold_request = 1'b1;
        src_idle_on = 1'b0;
        repeat (40) send_sample(pick_sample(32768), 1'b0);
      end else begin
        case ($urandom_range(19))
          0:       new_chans = 0;
          1:       new_chans = $urandom_range(9, 15);
          2:       new_chans = MAX_CHANNELS_DEF;
          default: new_chans = $urandom_range(1, 8);
        endcase
        case ($urandom_range(19))
          0:          new_win = 0;
          1:          new_win = 16'hFFFF;
          2:          new_win = $urandom_range(65535);
          3, 4, 5:    new_win = 1;
          default:    new_win = $urandom_range(2, 24);
        endcase
        case ($urandom_range(9))
          0:       new_quiet = 0;
          1:       new_quiet = 32768;
          2:       new_quiet = $urandom_range(65535);
          default: new_quiet = $urandom_range(4000);
        endcase
        case ($urandom_range(9))
          0:       new_loud = 0;
          1:       new_loud = 32768;
          2:       new_loud = $urandom_range(65535);
          default: new_loud = $urandom_range(2000, 32768);
        endcase
        write_settings(new_chans, new_win, new_quiet, new_loud);
        phase_target = samples_sent + $urandom_range(60, 120);
        while (samples_sent < phase_target) begin
          if (active_window <= 40) buf_frames = $urandom_range(1, 3 * active_window);
          else buf_frames = $urandom_range(1, 40);
          if (buf_frames * active_chans > 160) buf_frames = 160 / active_chans;
          send_buffer(buf_frames, $urandom_range(99) < 15, 1'b1);
        end
        // sometimes leave a window open across the next register change
        if ($urandom_range(99) < 35) send_buffer($urandom_range(1, 6), $urandom_range(1), 1'b0);
      end
    end

    drain_results();
    $display("Measured %0d windows from %0d samples under %0d register settings,",
             meter_sb.windows_checked, samples_sent, settings_used);
    $display("including clamped registers, buffer ends mid-frame and a stalled result side.");
    if (meter_sb.error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
